>>> rtl/core/emc_pkg.sv
// Shared types and constants of the edge midpoint cache.
package emc_pkg;

    localparam int VERT_W       = 20;
    localparam int KEY_SHIFT    = 32;
    localparam int KEY_W        = VERT_W + KEY_SHIFT;
    localparam int MOD_STEP     = 4;
    localparam int MOD_CYCLES   = KEY_W / MOD_STEP;
    localparam int MOD_CNT_W    = $clog2(MOD_CYCLES);
    localparam int TSIZE_W      = 13;
    localparam int EPOCH_W      = 4;
    localparam int ADDR_W       = 3;
    localparam int APB_DATA_W   = 32;
    localparam int TDATA_IN_W   = 40;
    localparam int TDATA_OUT_W  = 24;
    localparam int STATUS_W     = 3;

    localparam logic [TSIZE_W-1:0] RESET_TABLE_SIZE  = TSIZE_W'(240);
    localparam logic [VERT_W-1:0]  RESET_FIRST_INDEX = VERT_W'(12);
    localparam logic [EPOCH_W-1:0] EPOCH_EMPTY       = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST       = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST        = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_CREATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    typedef enum logic {
        REG_TABLE_SIZE  = 1'b0,
        REG_FIRST_INDEX = 1'b1
    } reg_idx_t;

endpackage

>>> rtl/core/edge_midpoint_cache.sv
// Edge midpoint cache: hashed slot table with linear probing for subdivision passes.
//
// Input channel (s_*): one transfer per edge. s_tuser is the kind (lookup or clear),
// s_tdata carries the two endpoint vertex indices. Result channel (m_*): exactly one
// transfer per input, status code on m_tuser, midpoint index on m_tdata.
// The APB port holds table_size (0x0) and first_new_index (0x4); writing the latter
// also reloads the running vertex counter. Write configuration only while idle.
//
// One item is worked at a time. A lookup reduces the key modulo the table size
// (4 key bits per cycle), reads the home slot from the slot memory, probes slots in
// turn until a hit, a free slot or a full table, and then moves its result into the
// output register; s_tready returns in the same cycle as m_tvalid. Probing runs
// through the slot memory's single read port. A clear goes through S_OUT into the
// output register; every 15th clear recycles the entry epoch tags and first sweeps
// the memory. After reset the slot memory is swept once, with s_tready low.
// A finished result waits in the output register while m_tready is low; the next
// item is still accepted and worked up to its own result, which then waits.
module edge_midpoint_cache
    import emc_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int INDEX_BITS  = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // vertex_a [19:0], vertex_b [39:20]
    input  logic [0:0]             s_tuser,   // kind [0]
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // midpoint_index [19:0], zero [23:20]
    output logic [STATUS_W-1:0]    m_tuser,   // status [2:0]
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int SW    = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (SW > TSIZE_W) ? SW : TSIZE_W;
    localparam int CNT_W = ((INDEX_BITS > VERT_W) ? INDEX_BITS : VERT_W) + 1;
    localparam int MW    = (INDEX_BITS > VERT_W) ? INDEX_BITS : VERT_W;
    localparam int DW    = EPOCH_W + 2 * VERT_W + INDEX_BITS;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [EPOCH_W-1:0]      epoch_reg, epoch_next;
    logic [AW-1:0]           sweep_cnt_reg, sweep_cnt_next;
    logic                    sweep_out_reg, sweep_out_next;
    logic [VERT_W-1:0]       lo_reg, lo_next;
    logic [VERT_W-1:0]       hi_reg, hi_next;
    logic [SW-1:0]           size_reg, size_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [AW-1:0]           rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]    hash_cnt_reg, hash_cnt_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [SW-1:0]           probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0]        vidx_reg, vidx_next;
    logic [VERT_W-1:0]       res_mid_reg, res_mid_next;
    status_t                 res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VERT_W-1:0]       m_mid_reg, m_mid_next;
    status_t                 m_status_reg, m_status_next;
    logic [TSIZE_W-1:0]      table_size_reg, table_size_next;
    logic [VERT_W-1:0]       first_index_reg, first_index_next;

    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic                    in_xfer;
    logic [VERT_W-1:0]       vert_a, vert_b;
    logic [CW-1:0]           tsize_ext;
    logic [SW-1:0]           active_size;
    logic [AW-1:0]           rem_step;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [DW-1:0]           ram_wdata, ram_rdata;

    logic [EPOCH_W-1:0]      ent_epoch;
    logic [VERT_W-1:0]       ent_lo, ent_hi;
    logic [INDEX_BITS-1:0]   ent_mid;
    logic                    ent_valid, ent_match;
    logic                    vidx_exhausted;
    logic [MW-1:0]           ent_mid_wide, new_mid_wide;
    logic [SW-1:0]           pos_inc;
    logic [AW-1:0]           pos_wrap;
    logic                    out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_TABLE_SIZE:  prdata = APB_DATA_W'(table_size_reg);
            REG_FIRST_INDEX: prdata = APB_DATA_W'(first_index_reg);
            default:         prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign vert_a   = s_tdata[VERT_W-1:0];
    assign vert_b   = s_tdata[2*VERT_W-1:VERT_W];

    // zero acts as one slot, oversize acts as the full memory
    assign tsize_ext = CW'(table_size_reg);
    always_comb begin
        priority if (tsize_ext == '0) begin
            active_size = SW'(1);
        end else if (tsize_ext > CW'(TABLE_DEPTH)) begin
            active_size = SW'(TABLE_DEPTH);
        end else begin
            active_size = SW'(tsize_ext);
        end
    end

    // restoring remainder, MOD_STEP key bits per cycle, MSB first
    always_comb begin
        logic [AW:0]   t;
        logic [AW-1:0] r;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < MOD_STEP; i++) begin
            t = {r, key_reg[KEY_W-1-i]};
            if (t >= (AW+1)'(size_reg)) begin
                t = t - (AW+1)'(size_reg);
            end
            r = t[AW-1:0];
        end
        rem_step = r;
    end

    // entry layout: {epoch, lo, hi, mid}; an entry is live only in the current epoch
    assign ent_epoch = ram_rdata[DW-1 -: EPOCH_W];
    assign ent_lo    = ram_rdata[INDEX_BITS+2*VERT_W-1 -: VERT_W];
    assign ent_hi    = ram_rdata[INDEX_BITS+VERT_W-1 -: VERT_W];
    assign ent_mid   = ram_rdata[INDEX_BITS-1:0];
    assign ent_valid = (ent_epoch == epoch_reg);
    assign ent_match = (ent_lo == lo_reg) && (ent_hi == hi_reg);

    assign vidx_exhausted = (vidx_reg >= (CNT_W'(1) << INDEX_BITS));
    assign ent_mid_wide   = MW'(ent_mid);
    assign new_mid_wide   = MW'(vidx_reg[INDEX_BITS-1:0]);

    assign pos_inc  = SW'(pos_reg) + SW'(1);
    assign pos_wrap = (pos_inc == size_reg) ? '0 : pos_inc[AW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        epoch_next       = epoch_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        sweep_out_next   = sweep_out_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        size_next        = size_reg;
        key_next         = key_reg;
        rem_next         = rem_reg;
        hash_cnt_next    = hash_cnt_reg;
        pos_next         = pos_reg;
        probe_cnt_next   = probe_cnt_reg;
        vidx_next        = vidx_reg;
        res_mid_next     = res_mid_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_mid_next       = m_mid_reg;
        m_status_next    = m_status_reg;
        table_size_next  = table_size_reg;
        first_index_next = first_index_reg;
        ram_we           = 1'b0;
        ram_waddr        = pos_reg;
        ram_wdata        = {epoch_reg, lo_reg, hi_reg, vidx_reg[INDEX_BITS-1:0]};
        ram_re           = 1'b0;
        ram_raddr        = pos_reg;

        unique case (state_reg)
            S_SWEEP: begin
                ram_we         = 1'b1;
                ram_waddr      = sweep_cnt_reg;
                ram_wdata      = {EPOCH_EMPTY, {(DW-EPOCH_W){1'b0}}};
                sweep_cnt_next = sweep_cnt_reg + AW'(1);
                if (sweep_cnt_reg == AW'(TABLE_DEPTH - 1)) begin
                    sweep_cnt_next = '0;
                    state_next     = sweep_out_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (kind_t'(s_tuser[0]) == KIND_CLEAR) begin
                        res_mid_next    = '0;
                        res_status_next = ST_CLEARED;
                        if (epoch_reg == EPOCH_LAST) begin
                            epoch_next     = EPOCH_FIRST;
                            sweep_out_next = 1'b1;
                            state_next     = S_SWEEP;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                            state_next = S_OUT;
                        end
                    end else begin
                        lo_next       = (vert_a < vert_b) ? vert_a : vert_b;
                        hi_next       = (vert_a < vert_b) ? vert_b : vert_a;
                        key_next      = {lo_next, {(KEY_SHIFT-VERT_W){1'b0}}, hi_next};
                        size_next     = active_size;
                        rem_next      = '0;
                        hash_cnt_next = '0;
                        state_next    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                rem_next      = rem_step;
                key_next      = key_reg << MOD_STEP;
                hash_cnt_next = hash_cnt_reg + MOD_CNT_W'(1);
                if (hash_cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                    pos_next       = rem_step;
                    probe_cnt_next = '0;
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                ram_re     = 1'b1;
                ram_raddr  = pos_reg;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // the only write of an item ends it, so reads never overlap a write
                priority if (!ent_valid) begin
                    if (vidx_exhausted) begin
                        res_mid_next    = '0;
                        res_status_next = ST_EXHAUSTED;
                    end else begin
                        ram_we          = 1'b1;
                        vidx_next       = vidx_reg + CNT_W'(1);
                        res_mid_next    = new_mid_wide[VERT_W-1:0];
                        res_status_next = ST_CREATED;
                    end
                    state_next = S_OUT;
                end else if (ent_match) begin
                    res_mid_next    = ent_mid_wide[VERT_W-1:0];
                    res_status_next = ST_FOUND;
                    state_next      = S_OUT;
                end else if (probe_cnt_reg + SW'(1) == size_reg) begin
                    res_mid_next    = '0;
                    res_status_next = ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    probe_cnt_next = probe_cnt_reg + SW'(1);
                    pos_next       = pos_wrap;
                    ram_re         = 1'b1;
                    ram_raddr      = pos_wrap;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_mid_next     = res_mid_reg;
                    m_status_next  = res_status_reg;
                    sweep_out_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TABLE_SIZE: begin
                    table_size_next = pwdata[TSIZE_W-1:0];
                end
                REG_FIRST_INDEX: begin
                    first_index_next = pwdata[VERT_W-1:0];
                    vidx_next        = CNT_W'(pwdata[VERT_W-1:0]);
                end
                default: begin
                    table_size_next = table_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            epoch_reg       <= EPOCH_FIRST;
            sweep_cnt_reg   <= '0;
            sweep_out_reg   <= 1'b0;
            vidx_reg        <= CNT_W'(RESET_FIRST_INDEX);
            m_valid_reg     <= 1'b0;
            table_size_reg  <= RESET_TABLE_SIZE;
            first_index_reg <= RESET_FIRST_INDEX;
        end else begin
            state_reg       <= state_next;
            epoch_reg       <= epoch_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            sweep_out_reg   <= sweep_out_next;
            vidx_reg        <= vidx_next;
            m_valid_reg     <= m_valid_next;
            table_size_reg  <= table_size_next;
            first_index_reg <= first_index_next;
        end
        // datapath registers, no reset needed
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        size_reg       <= size_next;
        key_reg        <= key_next;
        rem_reg        <= rem_next;
        hash_cnt_reg   <= hash_cnt_next;
        pos_reg        <= pos_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_mid_reg    <= res_mid_next;
        res_status_reg <= res_status_next;
        m_mid_reg      <= m_mid_next;
        m_status_reg   <= m_status_next;
    end

    emc_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(m_mid_reg);
    assign m_tuser  = m_status_reg;

endmodule

>>> rtl/core/emc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module emc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/emc_checker.sv
// Port-level checker for the edge midpoint cache, bound to the top level.
module emc_checker
    import emc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   pready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // error and clear results carry no midpoint
    a_zero_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_CLEARED
                     || m_tuser == ST_EXHAUSTED) |-> m_tdata == '0)
        else $error("nonzero midpoint on clear or error result");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // reset empties the output and holds off input during the sweep
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output valid or input ready right after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind edge_midpoint_cache emc_checker u_emc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

>>> sim/edge_midpoint_cache_tb.sv
// Self-checking testbench for the edge midpoint cache: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 100ps

module edge_midpoint_cache_tb;
    import emc_pkg::*;

    localparam int DEPTH         = 4096;
    localparam int IDX_BITS      = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = DEPTH + 100;
    localparam int IDLE_LIMIT    = 20000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 160;

    typedef struct packed {
        kind_t             kind;
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
    } edge_item_t;

    typedef struct packed {
        logic [VERT_W-1:0] mid;
        status_t           st;
    } midpoint_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    edge_midpoint_cache #(
        .TABLE_DEPTH(DEPTH),
        .INDEX_BITS (IDX_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the cache
    logic [TSIZE_W-1:0] tbl_size = RESET_TABLE_SIZE;
    logic [VERT_W:0]    next_index = {1'b0, RESET_FIRST_INDEX};
    logic [DEPTH-1:0]   slot_live = '0;
    logic [VERT_W-1:0]  slot_lo  [DEPTH];
    logic [VERT_W-1:0]  slot_hi  [DEPTH];
    logic [VERT_W-1:0]  slot_mid [DEPTH];

    edge_item_t       pending_edges[$];
    midpoint_result_t expected_mids[$];
    edge_item_t       cur_edge;

    bit idle_on = 1'b1;
    int gap_left = 0;
    int wait_left = 0;
    int hold_left = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int edges_sent = 0;
    int status_tally[5] = '{default: 0};

    function automatic midpoint_result_t resolve_edge(edge_item_t it);
        midpoint_result_t r;
        logic [VERT_W-1:0] lo, hi;
        logic [KEY_W-1:0]  key;
        int unsigned       span, pos, n;
        r.mid = '0;
        r.st  = ST_FULL;
        if (it.kind == KIND_CLEAR) begin
            slot_live = '0;
            r.st = ST_CLEARED;
            return r;
        end
        lo   = (it.va < it.vb) ? it.va : it.vb;
        hi   = (it.va < it.vb) ? it.vb : it.va;
        key  = {lo, {(KEY_SHIFT - VERT_W){1'b0}}, hi};
        span = (tbl_size == 0) ? 1 : ((tbl_size > DEPTH) ? DEPTH : tbl_size);
        pos  = int'(key % KEY_W'(span));
        for (n = 0; n < span; n++) begin
            if (!slot_live[pos]) begin
                if (next_index[VERT_W]) begin
                    r.st = ST_EXHAUSTED;
                end else begin
                    slot_lo[pos]   = lo;
                    slot_hi[pos]   = hi;
                    slot_mid[pos]  = next_index[VERT_W-1:0];
                    slot_live[pos] = 1'b1;
                    r.mid = next_index[VERT_W-1:0];
                    r.st  = ST_CREATED;
                    next_index++;
                end
                return r;
            end
            if (slot_lo[pos] == lo && slot_hi[pos] == hi) begin
                r.mid = slot_mid[pos];
                r.st  = ST_FOUND;
                return r;
            end
            pos = (pos + 1 == span) ? 0 : pos + 1;
        end
        return r;
    endfunction

    // input side: one transfer per queued edge, random gap after each while idle_on is set
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_mids.push_back(resolve_edge(cur_edge));
                edges_sent++;
                offer = 1'b0;
                gap_left = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_edges.size() > 0) begin
                    cur_edge = pending_edges.pop_front();
                    s_tdata <= {cur_edge.vb, cur_edge.va};
                    s_tuser <= cur_edge.kind;
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // result side: check each transfer, random stall after each while idle_on is set, long hold-off on request
    always @(posedge aclk) begin
        midpoint_result_t want;
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            wait_left = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_mids.size() == 0) begin
                    $error("unexpected result: midpoint_index %0h status %0d",
                           m_tdata[VERT_W-1:0], m_tuser);
                    errors++;
                end else begin
                    want = expected_mids.pop_front();
                    if (m_tdata[VERT_W-1:0] !== want.mid) begin
                        $error("midpoint_index: expected %0h, actual %0h",
                               want.mid, m_tdata[VERT_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[TDATA_OUT_W-1:VERT_W] !== '0) begin
                        $error("m_tdata padding: expected 0, actual %0h",
                               m_tdata[TDATA_OUT_W-1:VERT_W]);
                        errors++;
                    end
                    if (m_tuser !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, m_tuser);
                        errors++;
                    end
                    status_tally[int'(want.st)]++;
                end
                wait_left = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (hold_done != hold_asks) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // watchdog on stretches with no transfer on either stream
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic push_edge(input kind_t k, input int unsigned a, input int unsigned b);
        edge_item_t it;
        it.kind = k;
        it.va   = a[VERT_W-1:0];
        it.vb   = b[VERT_W-1:0];
        pending_edges.push_back(it);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_edges.size() != 0 || s_tvalid || expected_mids.size() != 0)
            @(negedge aclk);
    endtask

    // write one register, then read it back
    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_TABLE_SIZE) begin
            tbl_size = val[TSIZE_W-1:0];
        end else begin
            next_index = {1'b0, val[VERT_W-1:0]};
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== val) begin
            $error("prdata: expected %0h, actual %0h", val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle_and_config(input int unsigned size, input int unsigned first);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        reg_write(REG_TABLE_SIZE, size);
        reg_write(REG_FIRST_INDEX, first);
    endtask

    initial begin
        int unsigned sizes  [PHASES];
        int unsigned firsts [PHASES];
        int unsigned spans  [PHASES];
        int unsigned base, roll;
        int p, i;

        sizes  = '{16, 240, 1, 4096, 8191, 0, 37, 3000, 8, 240};
        firsts = '{0, 1000, 12, 524288, 1048515, 1048575, 77777, 33, 5000, 1048320};
        spans  = '{6, 22, 2, 40, 30, 3, 10, 60, 4, 25};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, endpoint extremes, order swap, equal endpoints, clear
        push_edge(KIND_LOOKUP, 5, 3);
        push_edge(KIND_LOOKUP, 3, 5);
        push_edge(KIND_LOOKUP, 0, 0);
        push_edge(KIND_LOOKUP, 20'hFFFFF, 20'hFFFFF);
        push_edge(KIND_LOOKUP, 0, 20'hFFFFF);
        push_edge(KIND_LOOKUP, 20'hFFFFF, 0);
        push_edge(KIND_CLEAR, 20'hFFFFF, 20'hFFFFF);
        push_edge(KIND_LOOKUP, 3, 5);

        // zero size acts as one slot; counter runs into the top of the index space
        settle_and_config(0, 20'hFFFFE);
        push_edge(KIND_LOOKUP, 1, 2);
        push_edge(KIND_LOOKUP, 2, 1);
        push_edge(KIND_LOOKUP, 7, 9);
        push_edge(KIND_CLEAR, 0, 0);
        push_edge(KIND_LOOKUP, 7, 9);
        push_edge(KIND_LOOKUP, 9, 7);
        push_edge(KIND_LOOKUP, 1, 1);
        push_edge(KIND_CLEAR, 0, 0);
        push_edge(KIND_LOOKUP, 4, 4);

        // counter runs out with room left: later misses fail, hits still work
        settle_and_config(8191, 20'hFFFFF);
        push_edge(KIND_LOOKUP, 10, 11);
        push_edge(KIND_LOOKUP, 12, 13);
        push_edge(KIND_LOOKUP, 11, 10);
        push_edge(KIND_LOOKUP, 4096, 0);
        push_edge(KIND_LOOKUP, 0, 4096);

        for (p = 0; p < PHASES; p++) begin
            settle_and_config(sizes[p], firsts[p]);
            idle_on = (p % 3 != 2);
            base = $urandom_range(0, 20'hFFFFF);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    push_edge(KIND_CLEAR, $urandom, $urandom);
                end else if (roll < 10) begin
                    push_edge(KIND_LOOKUP, $urandom, $urandom);
                end else begin
                    push_edge(KIND_LOOKUP, base + $urandom_range(0, spans[p]),
                              base + $urandom_range(0, spans[p]));
                end
            end
            // stall the result side while the sender keeps offering
            if (p == 1 || p == 7) hold_asks++;
        end

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Sent %0d edges over %0d table settings; zero, oversize and full-depth sizes",
                 edges_sent, PHASES + 2);
        $display("found %0d, created %0d, full %0d, cleared %0d, exhausted %0d",
                 status_tally[ST_FOUND], status_tally[ST_CREATED], status_tally[ST_FULL],
                 status_tally[ST_CLEARED], status_tally[ST_EXHAUSTED]);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/emc_pkg.sv
rtl/core/emc_ram.sv
rtl/core/edge_midpoint_cache.sv
rtl/core/emc_checker.sv
sim/edge_midpoint_cache_tb.sv
